/* rtl/core/oqrk_pkg.sv */
package oqrk_pkg;

  // Queue geometry
  localparam int QUEUE_DEPTH   = 16;
  localparam int TOKEN_BITS    = 16;
  // Width of the token fields on the ports
  localparam int TOKEN_FIELD_W = 16;
  // Bits actually kept per entry
  localparam int STORE_W = (TOKEN_BITS < TOKEN_FIELD_W) ? TOKEN_BITS : TOKEN_FIELD_W;
  localparam int IDX_W   = $clog2(QUEUE_DEPTH);
  localparam int CNT_W   = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [1:0] {
    OP_APPEND     = 2'd0,
    OP_REMOVE     = 2'd1,
    OP_DUMP_FRONT = 2'd2,
    OP_DUMP_BACK  = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_EMPTY     = 2'd1,
    ST_NOT_FOUND = 2'd2,
    ST_FULL      = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SEARCH,
    S_SHIFT,
    S_DUMP,
    S_RESP
  } state_t;

endpackage

/* rtl/core/oqrk_ram.sv */
module oqrk_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    // read data holds while re is low
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* rtl/core/ordered_queue_remove_by_key.sv */
// Ordered token queue with remove by key. One operation per input transfer
// (s_axis_tuser): append, remove the entry nearest the front equal to the
// token, dump front to back, or dump back to front. Items are handled one
// at a time; s_axis_tready is high only while the block is idle, but a new
// item is taken while the previous result still sits in the output
// register. Remove makes one pass through the entry RAM: it reads one entry
// per cycle, compares it, and after the match writes each later entry one
// place forward. A dump of N entries gives N result transfers at one per
// cycle while the output is not stalled, with m_axis_tlast on the final one;
// an empty queue gives a single result with status empty. Output stalls
// hold the sequencer. The store needs no clearing after reset: only the
// first count entries are ever read.
module ordered_queue_remove_by_key (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // [15:0] token_value
  input  logic [oqrk_pkg::TOKEN_FIELD_W-1:0]  s_axis_tdata,
  // [1:0] operation
  input  logic [1:0]                          s_axis_tuser,
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // [15:0] token_out
  output logic [oqrk_pkg::TOKEN_FIELD_W-1:0]  m_axis_tdata,
  // [1:0] status
  output logic [1:0]                          m_axis_tuser,
  output logic                                m_axis_tlast
);

  import oqrk_pkg::*;

  state_t             state, state_next;
  logic [CNT_W-1:0]   count, count_next;
  logic [IDX_W-1:0]   ptr, ptr_next;
  logic               back, back_next;   // dump direction
  logic [STORE_W-1:0] tok, tok_next;
  status_t            status_q, status_next;

  // output register
  logic               out_valid, out_valid_next;
  logic [STORE_W-1:0] out_tok;
  status_t            out_status;
  logic               out_last;

  logic               out_load;
  logic [STORE_W-1:0] load_tok;
  status_t            load_status;
  logic               load_last;

  // RAM port
  logic               ram_we, ram_re;
  logic [IDX_W-1:0]   ram_waddr, ram_raddr;
  logic [STORE_W-1:0] ram_wdata, ram_rdata;

  logic               in_fire, out_free, is_full, is_empty, at_last, match;
  logic [IDX_W-1:0]   last_idx, dump_end;
  op_t                op;

  assign op       = op_t'(s_axis_tuser);
  assign in_fire  = s_axis_tvalid && s_axis_tready;
  assign out_free = !out_valid || m_axis_tready;
  assign is_full  = (count == CNT_W'(QUEUE_DEPTH));
  assign is_empty = (count == '0);
  // only meaningful while the queue is not empty
  assign last_idx = IDX_W'(count - CNT_W'(1));
  assign at_last  = (ptr == last_idx);
  assign match    = (ram_rdata == tok);
  assign dump_end = back ? '0 : last_idx;

  assign s_axis_tready = (state == S_IDLE);

  oqrk_ram #(
    .WIDTH (STORE_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_comb begin
    state_next  = state;
    count_next  = count;
    ptr_next    = ptr;
    back_next   = back;
    tok_next    = tok;
    status_next = status_q;
    ram_we      = 1'b0;
    ram_waddr   = '0;
    ram_wdata   = '0;
    ram_re      = 1'b0;
    ram_raddr   = '0;
    out_load    = 1'b0;
    load_tok    = '0;
    load_status = ST_OK;
    load_last   = 1'b1;

    unique case (state)
      S_IDLE: begin
        if (in_fire) begin
          tok_next  = s_axis_tdata[STORE_W-1:0];
          back_next = (op == OP_DUMP_BACK);
          unique case (op)
            OP_APPEND: begin
              if (is_full) begin
                status_next = ST_FULL;
              end else begin
                ram_we      = 1'b1;
                ram_waddr   = IDX_W'(count);
                ram_wdata   = s_axis_tdata[STORE_W-1:0];
                count_next  = count + CNT_W'(1);
                status_next = ST_OK;
              end
              state_next = S_RESP;
            end
            OP_REMOVE: begin
              if (is_empty) begin
                status_next = ST_EMPTY;
                state_next  = S_RESP;
              end else begin
                ram_re     = 1'b1;
                ram_raddr  = '0;
                ptr_next   = '0;
                state_next = S_SEARCH;
              end
            end
            OP_DUMP_FRONT, OP_DUMP_BACK: begin
              if (is_empty) begin
                status_next = ST_EMPTY;
                state_next  = S_RESP;
              end else begin
                ram_re     = 1'b1;
                ram_raddr  = (op == OP_DUMP_BACK) ? last_idx : '0;
                ptr_next   = ram_raddr;
                state_next = S_DUMP;
              end
            end
            default: state_next = S_IDLE;
          endcase
        end
      end

      // rdata holds entry ptr; the next entry is fetched alongside
      S_SEARCH: begin
        if (at_last) begin
          if (match) begin
            count_next  = count - CNT_W'(1);
            status_next = ST_OK;
          end else begin
            status_next = ST_NOT_FOUND;
          end
          state_next = S_RESP;
        end else begin
          ram_re    = 1'b1;
          ram_raddr = ptr + IDX_W'(1);
          ptr_next  = ram_raddr;
          if (match) begin
            state_next = S_SHIFT;
          end
        end
      end

      // move entry ptr one place forward; writes stay behind the reads
      S_SHIFT: begin
        ram_we    = 1'b1;
        ram_waddr = ptr - IDX_W'(1);
        ram_wdata = ram_rdata;
        if (at_last) begin
          count_next  = count - CNT_W'(1);
          status_next = ST_OK;
          state_next  = S_RESP;
        end else begin
          ram_re    = 1'b1;
          ram_raddr = ptr + IDX_W'(1);
          ptr_next  = ram_raddr;
        end
      end

      S_DUMP: begin
        if (out_free) begin
          out_load    = 1'b1;
          load_tok    = ram_rdata;
          load_status = ST_OK;
          load_last   = (ptr == dump_end);
          if (ptr == dump_end) begin
            state_next = S_IDLE;
          end else begin
            ram_re     = 1'b1;
            ram_raddr  = back ? (ptr - IDX_W'(1)) : (ptr + IDX_W'(1));
            ptr_next   = ram_raddr;
          end
        end
      end

      S_RESP: begin
        if (out_free) begin
          out_load    = 1'b1;
          load_status = status_q;
          state_next  = S_IDLE;
        end
      end

      default: state_next = S_IDLE;
    endcase
  end

  assign out_valid_next = out_load || (out_valid && !m_axis_tready);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      count     <= count_next;
      out_valid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    ptr      <= ptr_next;
    back     <= back_next;
    tok      <= tok_next;
    status_q <= status_next;
    if (out_load) begin
      out_tok    <= load_tok;
      out_status <= load_status;
      out_last   <= load_last;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = TOKEN_FIELD_W'(out_tok);
  assign m_axis_tuser  = out_status;
  assign m_axis_tlast  = out_last;

endmodule

/* rtl/core/oqrk_checker.sv */
module oqrk_checker (
  input logic                                clk,
  input logic                                rst,
  input logic                                s_axis_tvalid,
  input logic                                s_axis_tready,
  input logic                                m_axis_tvalid,
  input logic                                m_axis_tready,
  input logic [oqrk_pkg::TOKEN_FIELD_W-1:0]  m_axis_tdata,
  input logic [1:0]                          m_axis_tuser,
  input logic                                m_axis_tlast
);

  import oqrk_pkg::*;

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)
      && $stable(m_axis_tlast))
    else $error("output changed under stall");

  // error results are single, final and carry no token
  a_err_form: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && (m_axis_tuser != ST_OK) |-> m_axis_tlast && (m_axis_tdata == '0))
    else $error("malformed error result");

  // nothing on the output straight after reset
  a_rst_idle: assert property (@(posedge clk)
    rst |=> !m_axis_tvalid)
    else $error("output valid after reset");

  // one item at a time: busy in the cycle after a transfer in
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input taken while busy");

endmodule

bind ordered_queue_remove_by_key oqrk_checker u_oqrk_checker (.*);
